// File: rtl/core/srb_pkg.sv
// Shared types and codes for the sequence reorder buffer.
`timescale 1ns / 1ps

package srb_pkg;

  typedef logic [31:0] seq_t;
  typedef logic [31:0] handle_t;

  typedef enum logic [1:0] {
    ST_INORDER   = 2'd0,
    ST_FLUSHED   = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_DISPLACED = 2'd3
  } status_t;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

endpackage

// File: rtl/core/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: control, slot valid bits, result register.
// One item is taken at a time: it is registered in S_IDLE and decided in S_DECIDE. An in-order
// item is emitted at once; each stored item drained behind it is read from the handle RAM,
// whose read port is registered, in S_DRAIN_RD and emitted in S_DRAIN_EMIT. A flush scans the
// slots from the head up to the last held item (all DEPTH slots when none is held) and reads
// out each held item. Results wait in an output register while the output is stalled.
// Out-of-window numbers come back with status rejected; a duplicate returns the displaced handle.
`timescale 1ns / 1ps

module sequence_reorder_buffer import srb_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] trigger,
  input  logic [31:0] item_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_handle,
  output logic [31:0] out_trigger,
  output logic [1:0]  status,
  output logic        last_of_run
);

  localparam int IW = $clog2(DEPTH);
  typedef logic [IW-1:0] idx_t;
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);
  localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DRAIN_RD,
    S_DRAIN_EMIT,
    S_DISP,
    S_SCAN,
    S_FLUSH_EMIT
  } state_t;

  function automatic idx_t inc_idx(idx_t i);
    return (i == LAST_IDX) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  state_t           state;
  seq_t             last_emitted;
  logic [DEPTH-1:0] slot_valid;
  idx_t             base;
  idx_t             scan_ptr;
  idx_t             scan_k;
  idx_t             dec_phys;
  logic             req_q;
  seq_t             trig_q;
  handle_t          hnd_q;

  seq_t             expected;
  seq_t             ahead;
  logic [IW:0]      store_sum;
  idx_t             store_phys;
  logic             in_window;
  idx_t             base_inc;
  logic             out_free;
  logic             out_load;
  logic [DEPTH-1:0] scan_bit;
  logic             flush_last;

  logic             ram_we;
  idx_t             ram_waddr;
  handle_t          ram_wdata;
  logic             ram_re;
  idx_t             ram_raddr;
  handle_t          rd_data;

  assign expected   = last_emitted + 32'd1;
  assign ahead      = trig_q - expected;
  assign store_sum  = {1'b0, base} + {1'b0, ahead[IW-1:0]};
  assign store_phys = (store_sum >= DEPTH_W) ? idx_t'(store_sum - DEPTH_W)
                                             : store_sum[IW-1:0];
  assign in_window  = (ahead != 32'd0) && (ahead < 32'(DEPTH));
  assign base_inc   = inc_idx(base);
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = out_free &&
                      ((state == S_DECIDE && req_q == REQ_ADD && !in_window) ||
                       state == S_DRAIN_EMIT || state == S_DISP || state == S_FLUSH_EMIT);
  assign scan_bit   = {{(DEPTH-1){1'b0}}, 1'b1} << scan_ptr;
  assign flush_last = (slot_valid & ~scan_bit) == '0;
  assign in_stall   = (state != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = store_phys;
    ram_wdata = hnd_q;
    ram_re    = 1'b0;
    ram_raddr = base;
    case (state)
      S_DECIDE: begin
        if (req_q == REQ_ADD && in_window) begin
          ram_we    = 1'b1;
          ram_re    = slot_valid[store_phys];
          ram_raddr = store_phys;
        end
      end
      S_DRAIN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = base;
      end
      S_SCAN: begin
        ram_re    = slot_valid[scan_ptr];
        ram_raddr = scan_ptr;
      end
      default: begin
      end
    endcase
  end

  srb_handle_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      last_emitted <= '1;
      slot_valid   <= '0;
      base         <= '0;
      scan_ptr     <= '0;
      scan_k       <= '0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q  <= req_type;
            trig_q <= trigger;
            hnd_q  <= item_handle;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (req_q == REQ_FLUSH) begin
            scan_ptr <= base;
            scan_k   <= '0;
            state    <= S_SCAN;
          end else if (ahead == 32'd0) begin
            if (out_free) begin
              out_handle   <= hnd_q;
              out_trigger  <= trig_q;
              status       <= ST_INORDER;
              last_of_run  <= !slot_valid[base_inc];
              last_emitted <= expected;
              slot_valid[base] <= 1'b0;
              base         <= base_inc;
              state        <= slot_valid[base_inc] ? S_DRAIN_RD : S_IDLE;
            end
          end else if (in_window) begin
            slot_valid[store_phys] <= 1'b1;
            dec_phys <= store_phys;
            state    <= slot_valid[store_phys] ? S_DISP : S_IDLE;
          end else if (out_free) begin
            out_handle  <= hnd_q;
            out_trigger <= trig_q;
            status      <= ST_REJECTED;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_DRAIN_RD: begin
          state <= S_DRAIN_EMIT;
        end
        S_DRAIN_EMIT: begin
          if (out_free) begin
            out_handle   <= rd_data;
            out_trigger  <= expected;
            status       <= ST_INORDER;
            last_of_run  <= !slot_valid[base_inc];
            last_emitted <= expected;
            slot_valid[base] <= 1'b0;
            base         <= base_inc;
            state        <= slot_valid[base_inc] ? S_DRAIN_RD : S_IDLE;
          end
        end
        S_DISP: begin
          if (out_free) begin
            out_handle  <= rd_data;
            out_trigger <= trig_q;
            status      <= ST_DISPLACED;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (slot_valid[scan_ptr]) begin
            state <= S_FLUSH_EMIT;
          end else if (scan_k == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            scan_ptr <= inc_idx(scan_ptr);
            scan_k   <= scan_k + idx_t'(1);
          end
        end
        S_FLUSH_EMIT: begin
          if (out_free) begin
            out_handle  <= rd_data;
            out_trigger <= expected + 32'(scan_k);
            status      <= ST_FLUSHED;
            last_of_run <= flush_last;
            slot_valid[scan_ptr] <= 1'b0;
            if (flush_last) begin
              state <= S_IDLE;
            end else begin
              scan_ptr <= inc_idx(scan_ptr);
              scan_k   <= scan_k + idx_t'(1);
              state    <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_head_slot_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !slot_valid[base])
    else $error("head slot valid while idle");

  a_disp_slot_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_DISP |-> slot_valid[dec_phys])
    else $error("displace without a held item");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH_EMIT && out_free && flush_last) |=> slot_valid == '0)
    else $error("slots left after flush");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (last_emitted != $past(last_emitted)) |->
      (last_emitted == $past(last_emitted) + 32'd1))
    else $error("sequence advanced by more than one");

endmodule

// File: rtl/core/srb_handle_ram.sv
// Handle store: one write port, one registered read port, read-first.
`timescale 1ns / 1ps

module srb_handle_ram import srb_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  handle_t                  wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output handle_t                  rdata
);

  handle_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
